// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define BNI_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked outside reset only.
`define BNI_ASSERT_DIS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- hw/rtl/bni_pkg.sv -----
// Package: payload types and sizes for the batch normalization block.
`timescale 1ns / 1ps
`default_nettype none
package bni_pkg;

   localparam int DEF_CHANNELS = 64;
   localparam int DIV_BITS     = 24;
   localparam int STD_W        = 13;
   localparam int SQRT_STEPS   = 13;
   localparam logic [15:0] EPS_RESET = 16'd1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [5:0]         channel;
      logic signed [15:0] sample;
      logic signed [15:0] mean_in;
      logic [15:0]        variance_in;
      logic signed [15:0] gain_in;
      logic signed [15:0] offset_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normalized;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] mean;
      logic [STD_W-1:0]   std;
      logic signed [15:0] gain;
      logic signed [15:0] offset;
   } entry_type;

endpackage
`default_nettype wire

// ----- hw/rtl/batchnorm_inference.sv -----
// Top level: batch normalization inference pipeline over a channel table.
// Pixels: one per cycle while req_stall is low (no load running, response not held).
// Load: runs through the serial square root unit, one root bit per cycle;
// requests are stalled meanwhile and the table entry is written on the last one.
// Synchronous active-high reset clears control state and sets epsilon to 1.
// The channel table is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module batchnorm_inference #(
   parameter int CHANNELS = bni_pkg::DEF_CHANNELS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bni_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bni_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data
);
   import bni_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ND = DIV_BITS;

   entry_type mem [CHANNELS];

   logic [15:0] eps_ff;
   logic        adv, acc, oor;
   logic [AW-1:0] addr;

   // config
   always_ff @(posedge clock) begin
      if (reset) eps_ff <= EPS_RESET;
      else if (csr_wr_en) eps_ff <= csr_wr_data;
   end

   assign oor  = (32'(req_data.channel) >= 32'(CHANNELS));
   assign addr = AW'(req_data.channel);

   // square root unit
   logic           sq_busy_ff;
   logic [3:0]     sq_cnt_ff;
   logic [25:0]    sq_v_ff, sq_v_in;
   logic [14:0]    sq_rem_ff, sq_rem_in;
   logic [STD_W-1:0] sq_root_ff, sq_root_in;
   logic [AW-1:0]  sq_addr_ff;
   logic signed [15:0] sq_mean_ff, sq_gain_ff, sq_off_ff;
   logic [16:0]    sq_rem_sh, sq_trial;

   assign req_stall = sq_busy_ff | ~adv;
   assign acc       = req_valid & ~req_stall;

   always_comb begin
      sq_rem_sh = {sq_rem_ff, sq_v_ff[25:24]};
      sq_trial  = {2'b00, sq_root_ff, 2'b01};
      sq_v_in   = {sq_v_ff[23:0], 2'b00};
      if (sq_rem_sh >= sq_trial) begin
         sq_rem_in  = 15'(sq_rem_sh - sq_trial);
         sq_root_in = {sq_root_ff[STD_W-2:0], 1'b1};
      end else begin
         sq_rem_in  = sq_rem_sh[14:0];
         sq_root_in = {sq_root_ff[STD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (acc && req_data.kind == KIND_LOAD && !oor) begin
         sq_busy_ff <= 1'b1;
      end else if (sq_busy_ff && sq_cnt_ff == 4'd0) begin
         sq_busy_ff <= 1'b0;
      end
      if (acc && req_data.kind == KIND_LOAD) begin
         sq_cnt_ff  <= 4'(SQRT_STEPS - 1);
         sq_v_ff    <= {1'b0, 17'(req_data.variance_in) + 17'(eps_ff), 8'd0};
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
         sq_addr_ff <= addr;
         sq_mean_ff <= req_data.mean_in;
         sq_gain_ff <= req_data.gain_in;
         sq_off_ff  <= req_data.offset_in;
      end else if (sq_busy_ff) begin
         sq_cnt_ff  <= sq_cnt_ff - 4'd1;
         sq_v_ff    <= sq_v_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
      end
   end

   // table memory
   entry_type rd_ff;
   always_ff @(posedge clock) begin
      if (sq_busy_ff && sq_cnt_ff == 4'd0)
         mem[sq_addr_ff] <= '{mean: sq_mean_ff, std: sq_root_in, gain: sq_gain_ff,
                              offset: sq_off_ff};
      if (adv) rd_ff <= mem[addr];
   end

   // stage 1: table data available
   logic               v1_ff, oor1_ff;
   logic signed [15:0] x1_ff;
   logic signed [16:0] d1;
   logic [16:0]        dmag1;

   assign d1    = 17'(x1_ff) - 17'(rd_ff.mean);
   assign dmag1 = d1[16] ? 17'(-d1) : d1;

   // divider stages
   logic               dv_ff   [ND+1];
   logic               door_ff [ND+1];
   logic               dneg_ff [ND+1];
   logic               dzero_ff[ND+1];
   logic [ND-1:0]      num_ff  [ND+1];
   logic [ND-1:0]      quo_ff  [ND+1];
   logic [STD_W-1:0]   rem_ff  [ND+1];
   logic [STD_W-1:0]   sd_ff   [ND+1];
   logic signed [15:0] gn_ff   [ND+1];
   logic signed [15:0] of_ff   [ND+1];

   // multiply stage
   logic               mv_ff, moor_ff, mneg_ff, mzero_ff, msdz_ff;
   logic signed [40:0] prod_ff;
   logic signed [15:0] mgn_ff, mof_ff;
   logic signed [24:0] qs;

   assign adv = ~(mv_ff & rsp_valid & rsp_stall);
   assign qs  = dneg_ff[ND] ? -$signed({1'b0, quo_ff[ND]}) : $signed({1'b0, quo_ff[ND]});

   always_ff @(posedge clock) begin
      logic [STD_W:0] r;
      if (reset) begin
         v1_ff <= 1'b0;
         for (int k = 0; k <= ND; k++) dv_ff[k] <= 1'b0;
         mv_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= acc & (req_data.kind == KIND_PIXEL);
         dv_ff[0] <= v1_ff;
         for (int k = 0; k < ND; k++) dv_ff[k+1] <= dv_ff[k];
         mv_ff    <= dv_ff[ND];
      end
      if (adv) begin
         x1_ff   <= req_data.sample;
         oor1_ff <= oor;
         door_ff[0]  <= oor1_ff;
         dneg_ff[0]  <= d1[16];
         dzero_ff[0] <= (d1 == 17'sd0);
         num_ff[0]   <= {dmag1[15:0], 8'd0};
         quo_ff[0]   <= '0;
         rem_ff[0]   <= '0;
         sd_ff[0]    <= rd_ff.std;
         gn_ff[0]    <= rd_ff.gain;
         of_ff[0]    <= rd_ff.offset;
         for (int k = 0; k < ND; k++) begin
            r = {rem_ff[k], num_ff[k][ND-1-k]};
            if (r >= {1'b0, sd_ff[k]}) begin
               rem_ff[k+1] <= STD_W'(r - {1'b0, sd_ff[k]});
               quo_ff[k+1] <= {quo_ff[k][ND-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= r[STD_W-1:0];
               quo_ff[k+1] <= {quo_ff[k][ND-2:0], 1'b0};
            end
            num_ff[k+1]   <= num_ff[k];
            door_ff[k+1]  <= door_ff[k];
            dneg_ff[k+1]  <= dneg_ff[k];
            dzero_ff[k+1] <= dzero_ff[k];
            sd_ff[k+1]    <= sd_ff[k];
            gn_ff[k+1]    <= gn_ff[k];
            of_ff[k+1]    <= of_ff[k];
         end
         prod_ff  <= 41'(qs) * 41'(gn_ff[ND]);
         moor_ff  <= door_ff[ND];
         mneg_ff  <= dneg_ff[ND];
         mzero_ff <= dzero_ff[ND];
         msdz_ff  <= (sd_ff[ND] == '0);
         mgn_ff   <= gn_ff[ND];
         mof_ff   <= of_ff[ND];
      end
   end

   // final stage: shift, bias, saturate
   logic signed [33:0] y;
   rsp_type            res;
   logic               gpos, gneg;

   assign y    = 34'(prod_ff >>> 8) + 34'(mof_ff);
   assign gpos = (mgn_ff > 16'sd0);
   assign gneg = mgn_ff[15];

   always_comb begin
      res.saturated  = 1'b0;
      res.normalized = y[15:0];
      if (moor_ff) begin
         res.normalized = '0;
         res.saturated  = 1'b1;
      end else if (msdz_ff) begin
         res.saturated = 1'b1;
         if (mzero_ff || !(gpos || gneg))
            res.normalized = mof_ff;
         else if (mneg_ff == gneg)
            res.normalized = 16'sh7FFF;
         else
            res.normalized = 16'sh8000;
      end else if (y > 34'sd32767) begin
         res.normalized = 16'sh7FFF;
         res.saturated  = 1'b1;
      end else if (y < -34'sd32768) begin
         res.normalized = 16'sh8000;
         res.saturated  = 1'b1;
      end
   end

   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mv_ff && adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (mv_ff && adv) rsp_data_ff <= res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/bni_checker.sv -----
// Port checker for the batch normalization block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bni_checker #(
   parameter int CHANNELS = bni_pkg::DEF_CHANNELS
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire bni_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bni_pkg::rsp_type rsp_data
);
   import bni_pkg::*;

   logic load_acc;
   logic held;
   assign load_acc = req_valid && !req_stall && req_data.kind == KIND_LOAD &&
                     (32'(req_data.channel) < 32'(CHANNELS));
   assign held     = rsp_valid && rsp_stall;

   `BNI_ASSERT(no_rsp_after_reset, clock, reset |=> !rsp_valid, "response valid after reset")
   `BNI_ASSERT_DIS(rsp_hold, clock, reset, held |=> rsp_valid && $stable(rsp_data), "rsp changed")
   `BNI_ASSERT_DIS(load_blocks, clock, reset, load_acc |=> req_stall, "request taken during load")

endmodule

bind batchnorm_inference bni_checker #(.CHANNELS(CHANNELS)) u_bni_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire
